>>> rtl/stag_pkg.sv
// Shared constants for the strided tensor address generator.
package stag_pkg;

    // Width of the linear position and of the seek index.
    localparam int POS_W = 32;
    // Width of the address as it leaves the block.
    localparam int OUT_ADDR_W = 32;
    // Bits of the shift counter used by the restoring divider.
    localparam int DIV_CNT_W = $clog2(POS_W);

    // Configuration port.
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W = 2;
    localparam int RANK_FIELD_W = 3;
    localparam int BASE_FIELD_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_DIM_EXTENTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_STRIDES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_RANK = 2'd3;

    // Operation codes carried in the input tuser.
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_SEEK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FWD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BWD = 2'd2;

endpackage

>>> rtl/strided_tensor_address_generator_top.sv
// Strided tensor address generator: sequencer, shared divider and multiplier.
//
// This block walks an N-dimensional strided view of memory. Each input word
// carries a mode in s_tuser (seek, step forward, step backward) and, for a
// seek, a signed linear index in s_tdata; each accepted word produces exactly
// one output word holding the element address (low bits) and the signed
// linear position (high bits). The block handles one word at a time: s_tready
// is high only while the sequencer is idle, and a finished result sits in an
// output register so that the next input word can be taken while the result
// waits for m_tready. A step without a carry needs a single digit check;
// every dimension that wraps before the carry stops adds a digit check, one
// pass through the shared multiplier and one accumulate. A seek runs the
// restoring divider over the 32-bit index once per active dimension, one
// quotient bit per cycle, followed by a multiply and an accumulate. A seek to
// an index of zero or below or with rank zero, a step at rank zero, a step
// from a position that does not move the address, and the unused mode go
// straight to the result stage. Configuration is written through cfg_wr_en,
// cfg_index and cfg_data; the user must write it only while no word is in
// flight, as the block itself does not enforce this. Extents of zero act as
// one, ranks above MAX_DIMS act as MAX_DIMS, and addresses wrap modulo
// 2^ADDRESS_BITS before being zero-extended or truncated to 32 bits.
module strided_tensor_address_generator_top #(
    parameter int MAX_DIMS     = 4,
    parameter int EXTENT_BITS  = 16,
    parameter int ADDRESS_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port.
    input  logic                                cfg_wr_en,
    input  logic [stag_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [stag_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [stag_pkg::POS_W-1:0]          s_tdata,  // [31:0] seek index
    input  logic [stag_pkg::MODE_W-1:0]         s_tuser,  // [1:0] mode
    // Output stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] address, [63:32] position
    output logic [stag_pkg::OUT_ADDR_W+stag_pkg::POS_W-1:0] m_tdata
);
    import stag_pkg::*;

    localparam int EB     = EXTENT_BITS;
    localparam int AW     = ADDRESS_BITS;
    localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CNT_W  = $clog2(MAX_DIMS + 1);
    localparam int PROD_W = 2 * EB + 1;
    localparam int OUT_W  = OUT_ADDR_W + POS_W;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_FWD  = 3'd4;
    localparam logic [2:0] ST_BWD  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    // Configuration registers.
    logic [EB-1:0]    ext_reg    [MAX_DIMS];
    logic [EB-1:0]    ext_next   [MAX_DIMS];
    logic [EB-1:0]    stride_reg [MAX_DIMS];
    logic [EB-1:0]    stride_next[MAX_DIMS];
    logic [AW-1:0]    base_reg, base_next;
    logic [CNT_W-1:0] rank_reg, rank_next;

    // Walk state.
    logic [EB-1:0]    digit_reg [MAX_DIMS];
    logic [EB-1:0]    digit_next[MAX_DIMS];
    logic [AW-1:0]    addr_reg, addr_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    // Sequencer and shared datapath.
    logic [2:0]           state_reg, state_next;
    logic [MODE_W-1:0]    op_reg, op_next;
    logic [DIM_W-1:0]     dim_reg, dim_next;
    logic [DIV_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [POS_W-1:0]     quot_reg, quot_next;
    logic [EB-1:0]        rem_reg, rem_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;

    // Output register.
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;

    // Datapath helpers.
    logic [EB-1:0]          ext_raw;
    logic [EB-1:0]          ext_sel;
    logic signed [EB-1:0]   stride_sel;
    logic [AW-1:0]          stride_ext;
    logic [EB-1:0]          digit_sel;
    logic [EB:0]            rem_shift;
    logic                   rem_ge;
    logic [EB:0]            rem_diff;
    logic [EB-1:0]          rem_new;
    logic signed [EB:0]     mul_a;
    logic [PROD_W+AW-1:0]   prod_wide;
    logic [AW-1:0]          prod_ext;
    logic                   dim_last;
    logic [POS_W-1:0]       pos_inc;
    logic [POS_W-1:0]       pos_dec;
    logic [POS_W-1:0]       idx;
    logic                   in_accept;
    logic [RANK_FIELD_W-1:0] rank_field;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign in_accept = s_tvalid && s_tready;
    assign idx       = s_tdata;
    assign pos_inc   = pos_reg + POS_W'(1);
    assign pos_dec   = pos_reg - POS_W'(1);

    // Per-dimension selection for the dimension under work.
    assign ext_raw    = ext_reg[dim_reg];
    assign ext_sel    = (ext_raw == '0) ? EB'(1) : ext_raw;
    assign stride_sel = $signed(stride_reg[dim_reg]);
    assign stride_ext = AW'(stride_sel);
    assign digit_sel  = digit_reg[dim_reg];
    assign dim_last   = ((CNT_W'(dim_reg) + CNT_W'(1)) == rank_reg);

    // One step of the restoring divider: shift in the next index bit.
    assign rem_shift = {rem_reg, quot_reg[POS_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, ext_sel});
    assign rem_diff  = rem_shift - {1'b0, ext_sel};
    assign rem_new   = rem_ge ? rem_diff[EB-1:0] : rem_shift[EB-1:0];

    // Multiplier operand: the digit on a seek, extent minus one on a wrap.
    assign mul_a = (op_reg == MODE_SEEK) ? $signed({1'b0, digit_sel})
                                         : $signed({1'b0, ext_sel - EB'(1)});

    // Sign-extend the product, then keep the address width.
    assign prod_wide = (PROD_W + AW)'(prod_reg);
    assign prod_ext  = prod_wide[AW-1:0];

    assign rank_field = cfg_data[RANK_FIELD_W-1:0];

    always_comb
    begin
        ext_next       = ext_reg;
        stride_next    = stride_reg;
        base_next      = base_reg;
        rank_next      = rank_reg;
        digit_next     = digit_reg;
        addr_next      = addr_reg;
        pos_next       = pos_reg;
        state_next     = state_reg;
        op_next        = op_reg;
        dim_next       = dim_reg;
        bit_cnt_next   = bit_cnt_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // Configuration writes; the field at the lowest bits is the innermost dimension.
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DIM_EXTENTS:
                begin
                    for (int k = 0; k < MAX_DIMS; k++)
                    begin
                        ext_next[k] = cfg_data[k*EB +: EB];
                    end
                end
                REG_DIM_STRIDES:
                begin
                    for (int k = 0; k < MAX_DIMS; k++)
                    begin
                        stride_next[k] = cfg_data[k*EB +: EB];
                    end
                end
                REG_BASE_OFFSET:
                begin
                    base_next = AW'(cfg_data[BASE_FIELD_W-1:0]);
                end
                REG_ACTIVE_RANK:
                begin
                    if (rank_field > RANK_FIELD_W'(MAX_DIMS))
                    begin
                        rank_next = CNT_W'(MAX_DIMS);
                    end
                    else
                    begin
                        rank_next = CNT_W'(rank_field);
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next    = s_tuser;
                    dim_next   = '0;
                    state_next = ST_DONE;
                    case (s_tuser)
                        MODE_SEEK:
                        begin
                            pos_next     = idx;
                            addr_next    = base_reg;
                            quot_next    = idx;
                            rem_next     = '0;
                            bit_cnt_next = DIV_CNT_W'(POS_W - 1);
                            for (int k = 0; k < MAX_DIMS; k++)
                            begin
                                digit_next[k] = '0;
                            end
                            if (!idx[POS_W-1] && (idx != '0) && (rank_reg != '0))
                            begin
                                state_next = ST_DIV;
                            end
                        end
                        MODE_FWD:
                        begin
                            pos_next = pos_inc;
                            if (!pos_reg[POS_W-1])
                            begin
                                if (rank_reg == '0)
                                begin
                                    addr_next = base_reg + AW'(pos_inc);
                                end
                                else
                                begin
                                    state_next = ST_FWD;
                                end
                            end
                        end
                        MODE_BWD:
                        begin
                            pos_next = pos_dec;
                            if (!pos_reg[POS_W-1] && (pos_reg != '0))
                            begin
                                if (rank_reg == '0)
                                begin
                                    addr_next = base_reg + AW'(pos_dec);
                                end
                                else
                                begin
                                    state_next = ST_BWD;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_DIV:
            begin
                rem_next     = rem_new;
                quot_next    = {quot_reg[POS_W-2:0], rem_ge};
                bit_cnt_next = bit_cnt_reg - DIV_CNT_W'(1);
                if (bit_cnt_reg == '0)
                begin
                    digit_next[dim_reg] = rem_new;
                    state_next          = ST_MUL;
                end
            end

            ST_MUL:
            begin
                prod_next  = mul_a * stride_sel;
                state_next = ST_ACC;
            end

            ST_ACC:
            begin
                // A forward wrap takes the whole dimension back; the others add.
                if (op_reg == MODE_FWD)
                begin
                    addr_next = addr_reg - prod_ext;
                end
                else
                begin
                    addr_next = addr_reg + prod_ext;
                end
                if (dim_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    dim_next = dim_reg + DIM_W'(1);
                    case (op_reg)
                        MODE_SEEK:
                        begin
                            rem_next     = '0;
                            bit_cnt_next = DIV_CNT_W'(POS_W - 1);
                            state_next   = ST_DIV;
                        end
                        MODE_FWD:
                        begin
                            state_next = ST_FWD;
                        end
                        default:
                        begin
                            state_next = ST_BWD;
                        end
                    endcase
                end
            end

            ST_FWD:
            begin
                if (({1'b0, digit_sel} + (EB+1)'(1)) < {1'b0, ext_sel})
                begin
                    digit_next[dim_reg] = digit_sel + EB'(1);
                    addr_next           = addr_reg + stride_ext;
                    state_next          = ST_DONE;
                end
                else
                begin
                    digit_next[dim_reg] = '0;
                    state_next          = ST_MUL;
                end
            end

            ST_BWD:
            begin
                if (digit_sel != '0)
                begin
                    digit_next[dim_reg] = digit_sel - EB'(1);
                    addr_next           = addr_reg - stride_ext;
                    state_next          = ST_DONE;
                end
                else
                begin
                    digit_next[dim_reg] = ext_sel - EB'(1);
                    state_next          = ST_MUL;
                end
            end

            ST_DONE:
            begin
                // Hand the result over once the output register is free.
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {pos_reg, OUT_ADDR_W'(addr_reg)};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_DIMS; k++)
            begin
                ext_reg[k]    <= '0;
                stride_reg[k] <= '0;
                digit_reg[k]  <= '0;
            end
            base_reg      <= '0;
            rank_reg      <= '0;
            addr_reg      <= '0;
            pos_reg       <= '0;
            state_reg     <= ST_IDLE;
            op_reg        <= MODE_SEEK;
            dim_reg       <= '0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ext_reg       <= ext_next;
            stride_reg    <= stride_next;
            digit_reg     <= digit_next;
            base_reg      <= base_next;
            rank_reg      <= rank_next;
            addr_reg      <= addr_next;
            pos_reg       <= pos_next;
            state_reg     <= state_next;
            op_reg        <= op_next;
            dim_reg       <= dim_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers of the divider, multiplier and output stage.
    always_ff @(posedge clk)
    begin
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the strided tensor address generator.
`timescale 1ns / 100ps

module testbench;

    import stag_pkg::*;

    // The fourth mode code has no name in the package; the block must leave its walk alone.
    localparam logic [MODE_W-1:0] MODE_HOLD = 2'd3;

    localparam int RESET_CYCLES = 6;
    // Random phases and the number of words each one sends.
    localparam int N_PHASES = 8;
    localparam int PHASE_WORDS = 185;
    // Long output stall used to back the block up onto its input.
    localparam int HOLD_CYCLES = 300;
    // Idle time at the end of the run, after the final drain.
    localparam int TAIL_CYCLES = 160;
    localparam int CYCLE_LIMIT = 2_000_000;

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_kind_t;

    // Tracks the walk state of the view and holds the address/position pairs still owed.
    class address_walk_scoreboard;

        typedef struct packed {
            logic [31:0] pos;
            logic [31:0] addr;
        } walk_result_t;

        logic [63:0]  extents;
        logic [63:0]  strides;
        logic [31:0]  base;
        logic [2:0]   rank;
        logic [15:0]  digit [4];
        logic [31:0]  cur_addr;
        logic [31:0]  cur_pos;
        walk_result_t owed_q [$];
        int unsigned  fault_count;
        int unsigned  checked_count;

        function new();
            extents = '0;
            strides = '0;
            base = '0;
            rank = '0;
            for (int k = 0; k < 4; k++)
                digit[k] = '0;
            cur_addr = '0;
            cur_pos = '0;
            fault_count = 0;
            checked_count = 0;
        endfunction

        function int rank_in_use();
            return (rank > 3'd4) ? 4 : int'(rank);
        endfunction

        // An extent of zero behaves as one.
        function logic [16:0] extent_at(int k);
            logic [15:0] e;
            e = extents[k*16 +: 16];
            return (e == 16'd0) ? 17'd1 : {1'b0, e};
        endfunction

        function logic [31:0] stride_at(int k);
            return {{16{strides[k*16+15]}}, strides[k*16 +: 16]};
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_DIM_EXTENTS: extents = data;
                REG_DIM_STRIDES: strides = data;
                REG_BASE_OFFSET: base = data[31:0];
                REG_ACTIVE_RANK: rank = data[2:0];
                default: ;
            endcase
        endfunction

        // Mixed-radix split of the index, innermost dimension fastest.
        function void seek_to(logic [31:0] index);
            logic [31:0] quot;
            logic [16:0] ext;
            int          dims;
            dims = rank_in_use();
            quot = index;
            cur_addr = base;
            cur_pos = index;
            for (int k = 0; k < 4; k++)
                digit[k] = '0;
            if (!index[31] && index != 32'd0 && dims > 0) begin
                for (int k = 0; k < dims; k++) begin
                    ext = extent_at(k);
                    digit[k] = 16'(quot % ext);
                    quot = quot / ext;
                    cur_addr = cur_addr + {16'd0, digit[k]} * stride_at(k);
                end
            end
        endfunction

        function void step_forward();
            logic [31:0] prev;
            logic [31:0] strd;
            logic [16:0] ext;
            int          dims;
            bit          carrying;
            prev = cur_pos;
            cur_pos = prev + 32'd1;
            dims = rank_in_use();
            if (prev[31])
                return;
            if (dims == 0) begin
                cur_addr = base + cur_pos;
                return;
            end
            carrying = 1'b1;
            for (int k = 0; k < dims; k++) begin
                if (carrying) begin
                    ext = extent_at(k);
                    strd = stride_at(k);
                    // A digit left at or above a shrunken extent also wraps here.
                    if ({1'b0, digit[k]} + 17'd1 < ext) begin
                        digit[k] = digit[k] + 16'd1;
                        cur_addr = cur_addr + strd;
                        carrying = 1'b0;
                    end
                    else begin
                        digit[k] = '0;
                        cur_addr = cur_addr - strd * (ext - 17'd1);
                    end
                end
            end
        endfunction

        function void step_backward();
            logic [31:0] prev;
            logic [31:0] strd;
            logic [16:0] ext;
            int          dims;
            bit          borrowing;
            prev = cur_pos;
            cur_pos = prev - 32'd1;
            dims = rank_in_use();
            if (prev[31] || prev == 32'd0)
                return;
            if (dims == 0) begin
                cur_addr = base + cur_pos;
                return;
            end
            borrowing = 1'b1;
            for (int k = 0; k < dims; k++) begin
                if (borrowing) begin
                    ext = extent_at(k);
                    strd = stride_at(k);
                    if (digit[k] != 16'd0) begin
                        digit[k] = digit[k] - 16'd1;
                        cur_addr = cur_addr - strd;
                        borrowing = 1'b0;
                    end
                    else begin
                        digit[k] = 16'(ext - 17'd1);
                        cur_addr = cur_addr + strd * (ext - 17'd1);
                    end
                end
            end
        endfunction

        function void note_word(logic [MODE_W-1:0] mode, logic [31:0] index);
            walk_result_t owed;
            case (mode)
                MODE_SEEK: seek_to(index);
                MODE_FWD:  step_forward();
                MODE_BWD:  step_backward();
                default: ;
            endcase
            owed.pos = cur_pos;
            owed.addr = cur_addr;
            owed_q.insert(owed_q.size(), owed);
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            fault_count++;
            if (fault_count <= 10)
                $display("MISMATCH %s: expected %h, got %h (result %0d)",
                         what, want, got, checked_count);
        endfunction

        function void check_result(logic [63:0] word);
            walk_result_t want;
            if (owed_q.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("MISMATCH unexpected result %h with nothing outstanding", word);
                return;
            end
            want = owed_q.pop_front();
            checked_count++;
            if (word[31:0] !== want.addr)
                flag("address", want.addr, word[31:0]);
            if (word[63:32] !== want.pos)
                flag("position", want.pos, word[63:32]);
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

    endclass

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [POS_W-1:0]              s_tdata;
    logic [MODE_W-1:0]             s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [OUT_ADDR_W+POS_W-1:0]   m_tdata;

    address_walk_scoreboard walk_sb;
    idle_kind_t  idle_mode = IDLE_NONE;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    int unsigned words_sent = 0;
    int unsigned cycle_count = 0;
    int unsigned views_programmed = 0;
    // Copy of the programmed shape, used only to aim seeks inside the view.
    logic [63:0] shape_extents;
    logic [2:0]  shape_rank;

    strided_tensor_address_generator_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, walk_sb.pending());
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic int src_idle_pct();
        return (idle_mode == IDLE_SRC) ? 68 : (idle_mode == IDLE_BOTH) ? 12 : 0;
    endfunction

    function automatic int sink_stall_pct();
        return (idle_mode == IDLE_SINK) ? 68 : (idle_mode == IDLE_BOTH) ? 12 : 0;
    endfunction

    // Output side. The long hold-off is counted here, so the sender keeps offering words
    // while the result register stays full and the block drops s_tready.
    always @(negedge clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct());
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            walk_sb.check_result(m_tdata);
    end

    // Offers one word, with random idle cycles ahead of it, and returns at the falling edge
    // after it was taken. The valid stays high there, so back-to-back words never drop it.
    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [31:0] index);
        int pct;
        pct = src_idle_pct();
        while ($urandom_range(99) < pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= index;
        do
            @(posedge clk);
        while (!s_tready);
        walk_sb.note_word(mode, index);
        words_sent++;
        @(negedge clk);
    endtask

    // Stops offering and waits until every owed result has arrived.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (walk_sb.pending() != 0)
            @(negedge clk);
    endtask

    // Writes all four registers while the block is idle. Bits above the base and the
    // rank are filled with noise, which the block must ignore.
    task automatic program_view(input logic [63:0] ext, input logic [63:0] strd,
                                input logic [31:0] base, input logic [2:0] rk);
        logic [CFG_DATA_W-1:0] value [4];
        logic [CFG_IDX_W-1:0]  reg_sel [4];
        reg_sel[0] = REG_DIM_EXTENTS;
        reg_sel[1] = REG_DIM_STRIDES;
        reg_sel[2] = REG_BASE_OFFSET;
        reg_sel[3] = REG_ACTIVE_RANK;
        value[0] = ext;
        value[1] = strd;
        value[2] = {$urandom, base};
        value[3] = {$urandom, 29'($urandom), rk};
        for (int k = 0; k < 4; k++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= reg_sel[k];
            cfg_data <= value[k];
            @(posedge clk);
            walk_sb.write_reg(reg_sel[k], value[k]);
            @(negedge clk);
        end
        cfg_wr_en <= 1'b0;
        shape_extents = ext;
        shape_rank = rk;
        views_programmed++;
    endtask

    // Number of elements in the programmed view.
    function automatic logic [63:0] view_span();
        logic [63:0] n;
        logic [15:0] e;
        int          dims;
        n = 64'd1;
        dims = (shape_rank > 3'd4) ? 4 : int'(shape_rank);
        for (int k = 0; k < dims; k++) begin
            e = shape_extents[k*16 +: 16];
            n = n * ((e == 16'd0) ? 64'd1 : {48'd0, e});
        end
        return n;
    endfunction

    // Seek targets: mostly inside the view, some at its far end, past it, at or below
    // zero, or anywhere in the 32-bit range.
    function automatic logic [31:0] seek_target();
        logic [63:0] span;
        logic [31:0] top;
        int unsigned roll;
        span = view_span();
        top = (span > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : span[31:0];
        roll = $urandom_range(99);
        if (roll < 55)
            return $urandom_range(top - 32'd1, 0);
        else if (roll < 65)
            return top - 32'd1 - ($urandom_range(3) % top);
        else if (roll < 75)
            return top + $urandom_range(50);
        else if (roll < 85)
            return 32'd0 - $urandom_range(100, 1);
        else if (roll < 90)
            return 32'd0;
        else
            return $urandom;
    endfunction

    function automatic logic [63:0] pick_extents();
        logic [63:0] v;
        int unsigned roll;
        for (int k = 0; k < 4; k++) begin
            roll = $urandom_range(99);
            if (roll < 8)
                v[k*16 +: 16] = 16'd0;
            else if (roll < 14)
                v[k*16 +: 16] = 16'hFFFF;
            else if (roll < 20)
                v[k*16 +: 16] = 16'($urandom);
            else
                v[k*16 +: 16] = 16'($urandom_range(6, 1));
        end
        return v;
    endfunction

    function automatic logic [63:0] pick_strides();
        logic [63:0] v;
        int unsigned roll;
        for (int k = 0; k < 4; k++) begin
            roll = $urandom_range(99);
            if (roll < 8)
                v[k*16 +: 16] = 16'h8000;
            else if (roll < 16)
                v[k*16 +: 16] = 16'h7FFF;
            else if (roll < 22)
                v[k*16 +: 16] = 16'd0;
            else if (roll < 30)
                v[k*16 +: 16] = 16'hFFFF;
            else
                v[k*16 +: 16] = 16'($urandom);
        end
        return v;
    endfunction

    function automatic logic [MODE_W-1:0] random_step();
        return $urandom_range(1) ? MODE_FWD : MODE_BWD;
    endfunction

    // A well-formed walk: a seek followed by a run of steps, sometimes all one way,
    // sometimes mixed.
    task automatic send_walk();
        int unsigned run_len;
        int unsigned style;
        run_len = $urandom_range(24, 1);
        style = $urandom_range(99);
        send_word(MODE_SEEK, seek_target());
        repeat (run_len) begin
            if (style < 50)
                send_word(MODE_FWD, $urandom);
            else if (style < 70)
                send_word(MODE_BWD, $urandom);
            else
                send_word(random_step(), $urandom);
        end
    endtask

    // Noise between walks: the unused mode, lone steps and wild seeks.
    task automatic send_noise();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 30)
            send_word(MODE_HOLD, $urandom);
        else if (roll < 60)
            send_word(random_step(), $urandom);
        else
            send_word(MODE_SEEK, $urandom);
    endtask

    initial begin
        logic [2:0]  rk;
        int unsigned goal;
        bit          paused;

        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        shape_extents = '0;
        shape_rank = '0;
        walk_sb = new();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed part. A 3 x 2 x 4 view whose strides hit both signed extremes and
        // whose base sits just below the top of the address space, so sums wrap.
        program_view(64'h0000_0004_0002_0003, 64'h1234_7FFF_8000_0001, 32'hFFFF_FFF0, 3'd3);
        send_word(MODE_SEEK, 32'd0);
        send_word(MODE_SEEK, 32'd5);
        send_word(MODE_FWD, 32'd0);          // carry ripples through two dimensions
        send_word(MODE_BWD, 32'd0);
        send_word(MODE_SEEK, 32'd23);        // last element of the view
        send_word(MODE_FWD, 32'd0);          // full wrap back to the first element
        send_word(MODE_SEEK, 32'd100);       // past the end, even the top digit wraps
        send_word(MODE_SEEK, 32'hFFFF_FFFB); // negative seek lands on the base
        send_word(MODE_FWD, 32'd0);          // from a negative position only the position moves
        send_word(MODE_SEEK, 32'd0);
        send_word(MODE_BWD, 32'd0);          // backward from zero only moves the position
        send_word(MODE_SEEK, 32'h7FFF_FFFF);
        send_word(MODE_FWD, 32'd0);          // position overflows to the most negative value
        send_word(MODE_FWD, 32'd0);
        send_word(MODE_SEEK, 32'h8000_0000);
        send_word(MODE_BWD, 32'd0);          // wraps back up to the most positive value
        send_word(MODE_HOLD, 32'hFFFF_FFFF); // unused mode reports the walk unchanged
        wait_drained();

        // Rank zero: a seek lands on the base and steps add the position to it.
        program_view(64'h0005_0007_0003_0002, 64'h0001_0002_0003_0004, 32'h0000_0010, 3'd0);
        send_word(MODE_FWD, 32'd0);
        send_word(MODE_BWD, 32'd0);
        send_word(MODE_SEEK, 32'd9);
        send_word(MODE_FWD, 32'd0);
        wait_drained();

        // All extents zero, strides of -1 and a rank above the supported four.
        program_view(64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 3'd7);
        send_word(MODE_SEEK, 32'd12);
        send_word(MODE_FWD, 32'd0);
        send_word(MODE_BWD, 32'd0);
        wait_drained();

        // Largest extents on every dimension and the top base address.
        program_view(64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_7FFF_8000_7FFF, 32'hFFFF_FFFF, 3'd4);
        send_word(MODE_SEEK, 32'h7FFF_FFFF);
        send_word(MODE_FWD, 32'd0);
        send_word(MODE_BWD, 32'd0);

        // Random phases, cycling through the idling patterns. Each new view is loaded
        // over the digits left by the previous walk, and the first few steps of a phase
        // run on those stale digits before any seek.
        for (int phase = 0; phase < N_PHASES; phase++) begin
            wait_drained();
            rk = ($urandom_range(99) < 10) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
            program_view(pick_extents(), pick_strides(),
                         ($urandom_range(9) == 0) ? {32{phase[0]}} : $urandom, rk);
            idle_mode = idle_kind_t'(phase % 4);
            if (phase == 4)
                hold_req = 1'b1;
            goal = words_sent + PHASE_WORDS;
            paused = 1'b0;
            repeat ($urandom_range(3, 1))
                send_word(random_step(), $urandom);
            while (words_sent < goal) begin
                // Once in the run the sender stops until every result is home.
                if (phase == 5 && !paused && words_sent + PHASE_WORDS / 2 >= goal) begin
                    wait_drained();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 80)
                    send_walk();
                else
                    send_noise();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (walk_sb.pending() != 0)
            $display("%0d results never arrived", walk_sb.pending());
        $display("testbench: %0d words over %0d views, %0d results checked, %0d mismatches",
                 words_sent, views_programmed, walk_sb.checked_count, walk_sb.fault_count);
        $display("testbench: seeks, steps both ways, unused mode, ranks 0 to 7, %s",
                 "zero and full extents, idling on both sides and a long output stall");
        if (walk_sb.fault_count == 0 && walk_sb.pending() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

>>> files.f
rtl/stag_pkg.sv
rtl/strided_tensor_address_generator_top.sv
dv/testbench.sv
